// ===== rtl/imm_pkg.sv =====
`default_nettype none

package imm_pkg;

	// Fixed field widths of the item and result words.
	localparam int IDX_W  = 3;
	localparam int VAL_W  = 32;
	localparam int DIM_W  = 4;
	localparam int CMD_W  = 2;
	localparam int CFG_IW = 2;

	// Command codes carried by the cmd field.
	localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IW-1:0] REG_ROWS_A = 2'd0;
	localparam logic [CFG_IW-1:0] REG_COLS_A = 2'd1;
	localparam logic [CFG_IW-1:0] REG_ROWS_B = 2'd2;
	localparam logic [CFG_IW-1:0] REG_COLS_B = 2'd3;

	typedef enum logic [1:0] {
		OP_LOAD_A,
		OP_LOAD_B,
		OP_COMPUTE
	} op_t;

	// One classified operation as it travels from the front to the back.
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
	} entry_t;

	// Matrix dimensions in use, already clamped to 1..MAX_DIM.
	typedef struct packed {
		logic [DIM_W-1:0] rows_a;
		logic [DIM_W-1:0] cols_a;
		logic [DIM_W-1:0] rows_b;
		logic [DIM_W-1:0] cols_b;
	} dims_t;

endpackage

`default_nettype wire

// ===== rtl/imm_front.sv =====
`default_nettype none

module imm_front #(
	parameter int MAX_DIM = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [imm_pkg::CMD_W-1:0]    cmd,
	input  wire logic [imm_pkg::IDX_W-1:0]    elem_row,
	input  wire logic [imm_pkg::IDX_W-1:0]    elem_col,
	input  wire logic [imm_pkg::VAL_W-1:0]    elem_value,
	input  wire logic                         cfg_write_en,
	input  wire logic [imm_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [imm_pkg::DIM_W-1:0]    cfg_data,
	output logic                              push_valid,
	input  wire logic                         push_ready,
	output imm_pkg::entry_t                   push_entry,
	output imm_pkg::dims_t                    dims
);
	import imm_pkg::*;

	localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0] rows_a_q;
	logic [DIM_W-1:0] cols_a_q;
	logic [DIM_W-1:0] rows_b_q;
	logic [DIM_W-1:0] cols_b_q;
	logic             in_store;
	logic             keep;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > MAX_D) begin
			r = MAX_D;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= DIM_W'(1);
			cols_a_q <= DIM_W'(1);
			rows_b_q <= DIM_W'(1);
			cols_b_q <= DIM_W'(1);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_ROWS_A: rows_a_q <= cfg_data;
				REG_COLS_A: cols_a_q <= cfg_data;
				REG_ROWS_B: rows_b_q <= cfg_data;
				REG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dims.rows_a = clamp_dim(rows_a_q);
	assign dims.cols_a = clamp_dim(cols_a_q);
	assign dims.rows_b = clamp_dim(rows_b_q);
	assign dims.cols_b = clamp_dim(cols_b_q);

	// Loads that fall outside the physical store are dropped, as are unused codes.
	assign in_store = ({1'b0, elem_row} < MAX_D) && ({1'b0, elem_col} < MAX_D);

	always_comb begin
		keep           = 1'b0;
		push_entry.op  = OP_COMPUTE;
		unique case (cmd)
			CMD_WRITE_A: begin
				keep          = in_store;
				push_entry.op = OP_LOAD_A;
			end
			CMD_WRITE_B: begin
				keep          = in_store;
				push_entry.op = OP_LOAD_B;
			end
			CMD_COMPUTE: begin
				keep          = 1'b1;
				push_entry.op = OP_COMPUTE;
			end
			CMD_UNUSED: begin
				keep = 1'b0;
			end
			default: ;
		endcase
	end

	assign push_entry.row   = elem_row;
	assign push_entry.col   = elem_col;
	assign push_entry.value = elem_value;

	assign in_ready   = push_ready;
	assign push_valid = in_valid && keep;

endmodule

`default_nettype wire

// ===== rtl/imm_queue.sv =====
`default_nettype none

module imm_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire imm_pkg::entry_t  push_entry,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output imm_pkg::entry_t       pop_entry
);
	import imm_pkg::*;

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/imm_back.sv =====
`default_nettype none

module imm_back #(
	parameter int MAX_DIM = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pop_valid,
	output logic                             pop_ready,
	input  wire imm_pkg::entry_t             pop_entry,
	input  wire imm_pkg::dims_t              dims,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [imm_pkg::IDX_W-1:0]        out_row,
	output logic [imm_pkg::IDX_W-1:0]        out_col,
	output logic [imm_pkg::VAL_W-1:0]        out_value,
	output logic                             out_last,
	output logic                             dim_error
);
	import imm_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             first;
		logic             last_k;
		logic             last_elem;
		logic             err;
	} tag_t;

	state_t           state_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic             err_q;

	logic [VAL_W-1:0] mem_a_q [DEPTH];
	logic [VAL_W-1:0] mem_b_q [DEPTH];
	logic [DEPTH-1:0] vld_a_q;
	logic [DEPTH-1:0] vld_b_q;

	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic              do_pop;
	logic              wr_a;
	logic              wr_b;
	logic              advance;
	logic              k_end;
	logic              j_end;
	logic              i_end;
	tag_t              tag_issue;

	logic             v_s1;
	tag_t             tag_s1;
	logic [VAL_W-1:0] a_s1;
	logic [VAL_W-1:0] b_s1;
	logic             v_s2;
	tag_t             tag_s2;
	logic [VAL_W-1:0] prod_s2;
	logic [VAL_W-1:0] prod_d;
	logic [VAL_W-1:0] acc_q;
	logic [VAL_W-1:0] sum_d;

	// The whole pipeline moves only when the output register can take a word.
	assign advance = !out_valid || out_ready;

	assign pop_ready = (state_q == ST_IDLE);
	assign do_pop    = pop_valid && pop_ready;
	assign wr_a      = do_pop && (pop_entry.op == OP_LOAD_A);
	assign wr_b      = do_pop && (pop_entry.op == OP_LOAD_B);
	assign wr_addr   = ADDR_W'(32'(pop_entry.row) * MAX_DIM + 32'(pop_entry.col));
	assign rd_addr_a = ADDR_W'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign rd_addr_b = ADDR_W'(32'(k_q) * MAX_DIM + 32'(j_q));

	assign k_end = err_q || (k_q == IDX_W'(dims.cols_a - DIM_W'(1)));
	assign j_end = err_q || (j_q == IDX_W'(dims.cols_b - DIM_W'(1)));
	assign i_end = err_q || (i_q == IDX_W'(dims.rows_a - DIM_W'(1)));

	assign tag_issue.row       = i_q;
	assign tag_issue.col       = j_q;
	assign tag_issue.first     = err_q || (k_q == '0);
	assign tag_issue.last_k    = k_end;
	assign tag_issue.last_elem = k_end && j_end && i_end;
	assign tag_issue.err       = err_q;

	// Sequencer walking i, j and the inner index k.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (do_pop && (pop_entry.op == OP_COMPUTE)) begin
						state_q <= ST_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						err_q   <= (dims.cols_a != dims.rows_b);
					end
				end
				ST_RUN: begin
					if (advance) begin
						if (!k_end) begin
							k_q <= k_q + IDX_W'(1);
						end else begin
							k_q <= '0;
							if (!j_end) begin
								j_q <= j_q + IDX_W'(1);
							end else begin
								j_q <= '0;
								if (!i_end) begin
									i_q <= i_q + IDX_W'(1);
								end else begin
									state_q <= ST_IDLE;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Element stores: one write port, one registered read port each.
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a_q[wr_addr] <= pop_entry.value;
		end
		if (wr_b) begin
			mem_b_q[wr_addr] <= pop_entry.value;
		end
	end

	// Entries never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_q <= '0;
			vld_b_q <= '0;
		end else begin
			if (wr_a) begin
				vld_a_q[wr_addr] <= 1'b1;
			end
			if (wr_b) begin
				vld_b_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1   <= vld_a_q[rd_addr_a] ? mem_a_q[rd_addr_a] : '0;
			b_s1   <= vld_b_q[rd_addr_b] ? mem_b_q[rd_addr_b] : '0;
			tag_s1 <= tag_issue;
		end
	end

	// Only the low half of the product is kept, which is all a wrapped sum needs.
	always_comb begin
		prod_d = a_s1 * b_s1;
		if (tag_s1.err) begin
			prod_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2 <= prod_d;
			tag_s2  <= tag_s1;
		end
	end

	assign sum_d = tag_s2.first ? prod_s2 : (acc_q + prod_s2);

	always_ff @(posedge clk) begin
		if (advance && v_s2) begin
			acc_q <= sum_d;
		end
		if (advance && v_s2 && tag_s2.last_k) begin
			out_row   <= tag_s2.row;
			out_col   <= tag_s2.col;
			out_value <= sum_d;
			out_last  <= tag_s2.last_elem;
			dim_error <= tag_s2.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			v_s1      <= (state_q == ST_RUN);
			v_s2      <= v_s1;
			out_valid <= v_s2 && tag_s2.last_k;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/integer_matrix_multiply_core.sv =====
`default_nettype none

// Channel   Handshake                  Word
// --------  -------------------------  ----------------------------------------------
// input     in_valid / in_ready        cmd, elem_row, elem_col, elem_value
// output    out_valid / out_ready      out_row, out_col, out_value, out_last, dim_error
// config    cfg_write_en (no wait)     cfg_index, cfg_data
//
// A load word passes through the queue and reaches its store once the back is idle.
// A compute word issues rows_a * cols_b * cols_a multiply-accumulate steps, one per
// cycle while the output is not stalled; a dimension error issues a single step, and
// a following compute is taken only after the sequencer returns to idle.
// Reset clears the configuration to one and marks every store entry as zero. A stalled
// output freezes the compute pipeline, and loads behind a compute wait in the queue.

module integer_matrix_multiply_core #(
	parameter int MAX_DIM = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [imm_pkg::CMD_W-1:0]   cmd,
	input  wire logic [imm_pkg::IDX_W-1:0]   elem_row,
	input  wire logic [imm_pkg::IDX_W-1:0]   elem_col,
	input  wire logic signed [imm_pkg::VAL_W-1:0] elem_value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [imm_pkg::IDX_W-1:0]        out_row,
	output logic [imm_pkg::IDX_W-1:0]        out_col,
	output logic signed [imm_pkg::VAL_W-1:0] out_value,
	output logic                             out_last,
	output logic                             dim_error,
	input  wire logic                        cfg_write_en,
	input  wire logic [imm_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [imm_pkg::DIM_W-1:0]   cfg_data
);
	import imm_pkg::*;

	// Classified words between the front and the queue, and the queue and the back.
	logic             push_valid;
	logic             push_ready;
	entry_t           push_entry;
	logic             pop_valid;
	logic             pop_ready;
	entry_t           pop_entry;
	dims_t            dims;
	logic [VAL_W-1:0] value_raw;

	// The front holds the configuration and sorts each incoming word into a
	// store load or a compute request; unused codes and loads outside the
	// store are swallowed here.
	imm_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.elem_row    (elem_row),
		.elem_col    (elem_col),
		.elem_value  (VAL_W'(unsigned'(elem_value))),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_entry  (push_entry),
		.dims        (dims)
	);

	// A short queue lets loads keep arriving while the back is busy.
	imm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	// The back owns both stores and the inner-product pipeline.
	imm_back #(
		.MAX_DIM(MAX_DIM)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_entry(pop_entry),
		.dims     (dims),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_row  (out_row),
		.out_col  (out_col),
		.out_value(value_raw),
		.out_last (out_last),
		.dim_error(dim_error)
	);

	assign out_value = signed'(value_raw);

endmodule

`default_nettype wire
